// ===== design/jtf_pkg.sv =====
package jtf_pkg;
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [1:0] ACT_SCAN = 2'd0;
	localparam logic [1:0] ACT_REWRITE = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [2:0] OP_OTHER = 3'd0;
	localparam logic [2:0] OP_NOP = 3'd1;
	localparam logic [2:0] OP_LABEL = 3'd2;
	localparam logic [2:0] OP_BR = 3'd3;
	localparam logic [2:0] OP_BR_IF = 3'd4;
	localparam logic [1:0] MIN_LENGTH = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] op_kind;
		logic signed [63:0] imm;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] imm_out;
		logic redirected;
		logic table_full;
	} out_word_t;
endpackage

// ===== design/jtf_if.sv =====
interface jtf_in_if;
	logic valid;
	logic ready;
	jtf_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface jtf_out_if;
	logic valid;
	logic ready;
	jtf_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/jtf_table.sv =====
module jtf_table (
	input logic clk,
	input logic we,
	input logic [jtf_pkg::IDX_W-1:0] waddr,
	input logic [127:0] wdata,
	input logic [jtf_pkg::IDX_W-1:0] raddr,
	output logic [127:0] rdata
);
	import jtf_pkg::*;
	logic [127:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/jump_target_forwarding_unit.sv =====
// Channel  Direction  Word
// in       sink       action, op_kind, imm
// out      source     imm_out, redirected, table_full
// Scan, clear and echoed rewrites show their result the cycle after acceptance.
// A rewrite that hits sweeps the table, one entry a cycle through the single
// memory read port, once per chain hop.
// Chains are cut after entry-count hops, the longest acyclic chain.
// Reset and clear empty the table at once through the entry count.
// A waiting result holds off the next word; the output stalls freely.
module jump_target_forwarding_unit (
	input logic clk,
	input logic arst_n,
	jtf_in_if.sink in_ch,
	jtf_out_if.source out_ch
);
	import jtf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SRCH = 2'd1;
	localparam logic [1:0] ST_OUT = 2'd2;

	logic [1:0] state_q;
	logic [CNT_W-1:0] count_q, idx_q, hops_q;
	logic rd_pend_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [63:0] key_q, first_q, imm_q;
	logic have_first_q;
	logic [63:0] pend_label_q;
	logic pend_valid_q, ovf_q;
	logic [1:0] len_q;
	out_word_t res_q;
	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [127:0] wdata, rdata;
	in_word_t w;
	logic acc;

	assign w = in_ch.data;
	assign acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.data = res_q;
	assign raddr = idx_q[IDX_W-1:0];
	assign we = acc && w.action == ACT_SCAN && w.op_kind == OP_BR && pend_valid_q
		&& !w.imm[63] && count_q < CNT_W'(TABLE_DEPTH);
	assign waddr = count_q[IDX_W-1:0];
	assign wdata = {pend_label_q, w.imm};

	jtf_table u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_valid_q <= 1'b0;
			pend_label_q <= '0;
			len_q <= '0;
			ovf_q <= 1'b0;
			rd_pend_q <= 1'b0;
			idx_q <= '0;
			hops_q <= '0;
			have_first_q <= 1'b0;
		end else begin
			case (state_q)
			ST_IDLE: begin
				if (acc) begin
					res_q <= '{imm_out: w.imm, redirected: 1'b0, table_full: ovf_q};
					state_q <= ST_OUT;
					case (w.action)
					ACT_SCAN: begin
						if (len_q < MIN_LENGTH) len_q <= len_q + 2'd1;
						if (w.op_kind != OP_NOP) begin
							if (w.op_kind == OP_BR && pend_valid_q && !w.imm[63]) begin
								if (count_q < CNT_W'(TABLE_DEPTH)) begin
									count_q <= count_q + CNT_W'(1);
								end else begin
									ovf_q <= 1'b1;
									res_q.table_full <= 1'b1;
								end
							end
							pend_valid_q <= (w.op_kind == OP_LABEL) && !w.imm[63];
							pend_label_q <= w.imm;
						end
					end
					ACT_REWRITE: begin
						if (len_q == MIN_LENGTH && (w.op_kind == OP_BR || w.op_kind == OP_BR_IF)
							&& !w.imm[63] && count_q != '0) begin
							state_q <= ST_SRCH;
							key_q <= w.imm;
							imm_q <= w.imm;
							idx_q <= '0;
							hops_q <= '0;
							rd_pend_q <= 1'b0;
							have_first_q <= 1'b0;
						end
					end
					ACT_CLEAR: begin
						count_q <= '0;
						pend_valid_q <= 1'b0;
						pend_label_q <= '0;
						len_q <= '0;
						ovf_q <= 1'b0;
						res_q.table_full <= 1'b0;
					end
					default: begin
					end
					endcase
				end
			end
			ST_SRCH: begin
				if (rd_pend_q && rdata[127:64] == key_q) begin
					rd_pend_q <= 1'b0;
					idx_q <= '0;
					if (!have_first_q) begin
						have_first_q <= 1'b1;
						first_q <= rdata[63:0];
						key_q <= rdata[63:0];
					end else if (hops_q == count_q) begin
						res_q.imm_out <= first_q;
						res_q.redirected <= first_q != imm_q;
						state_q <= ST_OUT;
					end else begin
						hops_q <= hops_q + CNT_W'(1);
						key_q <= rdata[63:0];
					end
				end else if (rd_pend_q && idx_q == count_q) begin
					res_q.imm_out <= key_q;
					res_q.redirected <= have_first_q && key_q != imm_q;
					state_q <= ST_OUT;
				end else if (idx_q == count_q) begin
					rd_pend_q <= 1'b1;
				end else begin
					rd_pend_q <= 1'b1;
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			ST_OUT: begin
				if (out_ch.ready) state_q <= ST_IDLE;
			end
			default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_q))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> !in_ch.ready)
		else $error("input taken during search");
endmodule

// ===== tb/jump_target_forwarding_unit_test.sv =====
`timescale 1ns / 100ps

module jump_target_forwarding_unit_test;
	import jtf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	jtf_in_if in_ch ();
	jtf_out_if out_ch ();

	jump_target_forwarding_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state for the current function.
	logic [63:0] fwd_label [TABLE_DEPTH];
	logic [63:0] fwd_target [TABLE_DEPTH];
	int fwd_count;
	logic [63:0] wait_label;
	bit wait_valid;
	int seen_len;
	bit dropped;

	out_word_t expected_words [$];
	int failures = 0;
	int idle_cycles = 0;
	bit sender_done = 1'b0;
	bit hold_sink = 1'b0;

	function automatic void clear_fwd();
		fwd_count = 0;
		wait_label = '0;
		wait_valid = 1'b0;
		seen_len = 0;
		dropped = 1'b0;
	endfunction

	function automatic int lookup_label(logic [63:0] id);
		for (int i = 0; i < fwd_count; i++) begin
			if (fwd_label[i] == id)
				return i;
		end
		return fwd_count;
	endfunction

	function automatic out_word_t thread_word(in_word_t w);
		out_word_t r;
		int first;
		int at;
		logic [63:0] tgt;
		bit marks [TABLE_DEPTH];
		r.imm_out = w.imm;
		r.redirected = 1'b0;
		if (w.action == ACT_SCAN) begin
			if (seen_len < 3)
				seen_len++;
			if (w.op_kind != OP_NOP) begin
				if (w.op_kind == OP_BR && wait_valid && !w.imm[63]) begin
					if (fwd_count < TABLE_DEPTH) begin
						fwd_label[fwd_count] = wait_label;
						fwd_target[fwd_count] = w.imm;
						fwd_count++;
					end else begin
						dropped = 1'b1;
					end
				end
				if (w.op_kind == OP_LABEL && !w.imm[63]) begin
					wait_label = w.imm;
					wait_valid = 1'b1;
				end else begin
					wait_valid = 1'b0;
				end
			end
		end else if (w.action == ACT_REWRITE) begin
			if (seen_len >= 3 && (w.op_kind == OP_BR || w.op_kind == OP_BR_IF)
					&& !w.imm[63]) begin
				first = lookup_label(w.imm);
				if (first < fwd_count) begin
					foreach (marks[i])
						marks[i] = 1'b0;
					marks[first] = 1'b1;
					tgt = fwd_target[first];
					forever begin
						at = lookup_label(tgt);
						if (at >= fwd_count)
							break;
						if (marks[at]) begin
							tgt = fwd_target[first];
							break;
						end
						marks[at] = 1'b1;
						tgt = fwd_target[at];
					end
					r.imm_out = tgt;
					r.redirected = (tgt != w.imm);
				end
			end
		end else if (w.action == ACT_CLEAR) begin
			clear_fwd();
		end
		r.table_full = dropped;
		return r;
	endfunction

	task automatic send_word(in_word_t w);
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do
			@(posedge clk);
		while (!in_ch.ready);
		expected_words.push_back(thread_word(w));
	endtask

	task automatic sender_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		if (n > 0) begin
			in_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic in_word_t mk(logic [1:0] a, logic [2:0] o, logic [63:0] v);
		in_word_t w;
		w.action = a;
		w.op_kind = o;
		w.imm = v;
		return w;
	endfunction

	function automatic logic [63:0] rand_id();
		case ($urandom_range(0, 9))
			0: return {$urandom, $urandom};
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return 64'h8000_0000_0000_0000;
			default: return 64'($urandom_range(0, 12));
		endcase
	endfunction

	// Directed words; a known result is checked where one is given.
	typedef struct {
		in_word_t w;
		bit known;
		out_word_t r;
	} row_t;

	task automatic run_directed();
		row_t rows [$];
		rows.push_back('{mk(ACT_REWRITE, OP_BR, 64'd5), 1, '{64'd5, 1'b0, 1'b0}});
		rows.push_back('{mk(ACT_SCAN, OP_LABEL, 64'd1), 1, '{64'd1, 1'b0, 1'b0}});
		rows.push_back('{mk(ACT_SCAN, OP_NOP, 64'd0), 1, '{64'd0, 1'b0, 1'b0}});
		rows.push_back('{mk(ACT_SCAN, OP_BR, 64'd2), 1, '{64'd2, 1'b0, 1'b0}});
		rows.push_back('{mk(ACT_SCAN, OP_LABEL, 64'd2), 0, '0});
		rows.push_back('{mk(ACT_SCAN, OP_BR, 64'd3), 0, '0});
		rows.push_back('{mk(ACT_SCAN, OP_LABEL, 64'd1), 0, '0});
		rows.push_back('{mk(ACT_SCAN, OP_BR, 64'd9), 0, '0});
		rows.push_back('{mk(ACT_SCAN, OP_LABEL, 64'h7fff_ffff_ffff_ffff), 0, '0});
		rows.push_back('{mk(ACT_SCAN, OP_BR, 64'h7fff_ffff_ffff_ffff), 0, '0});
		rows.push_back('{mk(ACT_SCAN, OP_LABEL, 64'h8000_0000_0000_0000), 0, '0});
		rows.push_back('{mk(ACT_SCAN, OP_BR, 64'd4), 0, '0});
		rows.push_back('{mk(ACT_SCAN, OP_LABEL, 64'd6), 0, '0});
		rows.push_back('{mk(ACT_SCAN, 3'd7, 64'd0), 0, '0});
		rows.push_back('{mk(ACT_SCAN, OP_BR, 64'hffff_ffff_ffff_ffff), 0, '0});
		rows.push_back('{mk(ACT_REWRITE, OP_BR, 64'd1), 1, '{64'd3, 1'b1, 1'b0}});
		rows.push_back('{mk(ACT_REWRITE, OP_BR_IF, 64'd2), 1, '{64'd3, 1'b1, 1'b0}});
		rows.push_back('{mk(ACT_REWRITE, OP_BR, 64'h7fff_ffff_ffff_ffff), 0, '0});
		rows.push_back('{mk(ACT_REWRITE, OP_OTHER, 64'd1), 1, '{64'd1, 1'b0, 1'b0}});
		rows.push_back('{mk(ACT_REWRITE, OP_BR, 64'hffff_ffff_ffff_ffff), 1,
			'{64'hffff_ffff_ffff_ffff, 1'b0, 1'b0}});
		rows.push_back('{mk(2'd3, OP_BR, 64'd1), 1, '{64'd1, 1'b0, 1'b0}});
		rows.push_back('{mk(ACT_CLEAR, OP_OTHER, 64'd0), 1, '{64'd0, 1'b0, 1'b0}});
		rows.push_back('{mk(ACT_SCAN, 3'd5, 64'd0), 0, '0});
		rows.push_back('{mk(ACT_SCAN, 3'd6, 64'd0), 0, '0});
		foreach (rows[i]) begin
			send_word(rows[i].w);
			if (rows[i].known && expected_words[$] != rows[i].r) begin
				$display("%0t directed row %0d: expected %h, actual %h", $time, i,
					rows[i].r, expected_words[$]);
				failures++;
			end
			sender_gap();
		end
	endtask

	// Fills the table past its depth to drop an entry and set the full flag.
	task automatic run_overflow();
		send_word(mk(ACT_CLEAR, OP_OTHER, 64'd0));
		for (int i = 0; i <= TABLE_DEPTH; i++) begin
			send_word(mk(ACT_SCAN, OP_LABEL, 64'(i + 100)));
			send_word(mk(ACT_SCAN, OP_BR, 64'(i + 101)));
		end
		send_word(mk(ACT_REWRITE, OP_BR, 64'd300));
		send_word(mk(ACT_REWRITE, OP_BR, 64'd355));
		send_word(mk(ACT_CLEAR, OP_OTHER, 64'd0));
	endtask

	task automatic run_random(int count);
		in_word_t w;
		int sent;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 19))
				0: w = mk(ACT_CLEAR, 3'($urandom), {$urandom, $urandom});
				1: w = mk(2'($urandom), 3'($urandom), {$urandom, $urandom});
				2, 3, 4, 5, 6: w = mk(ACT_SCAN, OP_LABEL, rand_id());
				7, 8, 9, 10: w = mk(ACT_SCAN, OP_BR, rand_id());
				11: w = mk(ACT_SCAN, 3'($urandom_range(0, 7)), rand_id());
				default: w = mk(ACT_REWRITE,
					$urandom_range(0, 4) == 0 ? 3'($urandom) :
					($urandom_range(0, 1) ? OP_BR : OP_BR_IF), rand_id());
			endcase
			send_word(w);
			sender_gap();
			sent++;
			if (sent == count / 2) begin
				in_ch.valid <= 1'b0;
				wait (expected_words.size() == 0);
				@(posedge clk);
			end
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		clear_fwd();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		hold_sink <= 1'b1;
		run_random(50);
		run_overflow();
		run_random(50);
		in_ch.valid <= 1'b0;
		sender_done <= 1'b1;
	end

	initial begin
		out_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				hold_sink <= 1'b0;
				out_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				out_ch.ready <= 1'b0;
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : 1)
					@(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		out_word_t exp_w;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t unexpected word: expected none, actual %h", $time,
					out_ch.data);
				failures++;
			end else begin
				exp_w = expected_words.pop_front();
				if (out_ch.data.imm_out !== exp_w.imm_out) begin
					$display("%0t imm_out: expected %h, actual %h", $time,
						exp_w.imm_out, out_ch.data.imm_out);
					failures++;
				end
				if (out_ch.data.redirected !== exp_w.redirected) begin
					$display("%0t redirected: expected %b, actual %b", $time,
						exp_w.redirected, out_ch.data.redirected);
					failures++;
				end
				if (out_ch.data.table_full !== exp_w.table_full) begin
					$display("%0t table_full: expected %b, actual %b", $time,
						exp_w.table_full, out_ch.data.table_full);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (arst_n);
		fork
			begin
				wait (sender_done && expected_words.size() == 0);
				repeat (10) @(posedge clk);
			end
			wait (idle_cycles >= 300000);
		join_any
		if (failures == 0 && expected_words.size() == 0 && idle_cycles < 300000)
			$display("jump_target_forwarding_unit: match");
		else
			$display("jump_target_forwarding_unit: mismatch");
		$finish;
	end
endmodule

// ===== jump_target_forwarding_unit.f =====
design/jtf_pkg.sv
design/jtf_if.sv
design/jtf_table.sv
design/jump_target_forwarding_unit.sv
tb/jump_target_forwarding_unit_test.sv
